// ===== rtl/linear_probe_hash_table_defines.svh =====
// Assertion macros for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define LPH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash table assertion failed");

// Next-cycle implication, disabled during reset
`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash table assertion failed");

`else

`define LPH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lph_pkg.sv =====
// Types and codes shared by the linear probing hash table.
`default_nettype none

package lph_pkg;

   localparam int KEY_W = 32;

   // Command codes
   localparam logic CMD_SEARCH = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_SEARCH    = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_ZERO_KEY  = 3'd4;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [2:0] status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/lph_mod_unit.sv =====
// Remainder unit: key modulo the table size by reciprocal multiplication on one multiplier.
`default_nettype none

module lph_mod_unit #(
   parameter int TABLE_SLOTS = 128
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [lph_pkg::KEY_W-1:0]        op_key,
   output logic                                  done,
   output logic [$clog2(TABLE_SLOTS)-1:0]        rem
);

   localparam int IDX_W     = $clog2(TABLE_SLOTS);
   localparam int WIDE_W    = 2 * lph_pkg::KEY_W;
   localparam int FLOOR_LOG = $clog2(TABLE_SLOTS + 1) - 1;
   localparam int SHIFT     = lph_pkg::KEY_W + FLOOR_LOG;
   // Reciprocal rounded down, so the quotient estimate is never too large
   localparam logic [WIDE_W-1:0] MAGIC_WIDE =
      ((WIDE_W'(1) << SHIFT) - WIDE_W'(1)) / WIDE_W'(TABLE_SLOTS);
   localparam logic [lph_pkg::KEY_W-1:0] MAGIC   = MAGIC_WIDE[lph_pkg::KEY_W-1:0];
   localparam logic [lph_pkg::KEY_W-1:0] DIVISOR = lph_pkg::KEY_W'(TABLE_SLOTS);
   localparam logic [IDX_W:0]            DIV_N   = (IDX_W + 1)'(TABLE_SLOTS);

   // Sequencer phases
   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_MUL  = 3'd1;
   localparam logic [2:0] P_QUOT = 3'd2;
   localparam logic [2:0] P_SUB  = 3'd3;
   localparam logic [2:0] P_FIX  = 3'd4;

   logic [2:0]                  phase_ff, phase_in;
   logic [lph_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [WIDE_W-1:0]           prod_ff, prod_in;
   logic [IDX_W:0]              rem_ff, rem_in;
   logic [lph_pkg::KEY_W-1:0]   quot_est;
   logic [lph_pkg::KEY_W-1:0]   mul_a;
   logic [lph_pkg::KEY_W-1:0]   mul_b;
   logic [WIDE_W-1:0]           mul_p;
   logic                        rem_big;

   // Feed the shared multiplier: key by reciprocal, then quotient by table size
   always_comb begin
      quot_est = lph_pkg::KEY_W'(prod_ff >> SHIFT);
      mul_a    = key_ff;
      mul_b    = MAGIC;
      if (phase_ff == P_QUOT) begin
         mul_a = quot_est;
         mul_b = DIVISOR;
      end
      mul_p   = WIDE_W'(mul_a) * WIDE_W'(mul_b);
      rem_big = (rem_ff >= DIV_N);
   end

   // Step through multiply, back-multiply, subtract and at most one correction
   always_comb begin
      phase_in = phase_ff;
      key_in   = key_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      case (phase_ff)
         P_IDLE: begin
            if (start) begin
               key_in   = op_key;
               phase_in = P_MUL;
            end
         end
         P_MUL: begin
            prod_in  = mul_p;
            phase_in = P_QUOT;
         end
         P_QUOT: begin
            prod_in  = mul_p;
            phase_in = P_SUB;
         end
         P_SUB: begin
            rem_in   = (IDX_W + 1)'(key_ff - prod_ff[lph_pkg::KEY_W-1:0]);
            phase_in = P_FIX;
         end
         P_FIX: begin
            if (rem_big) begin
               rem_in = rem_ff - DIV_N;
            end else begin
               phase_in = P_IDLE;
            end
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = (phase_ff == P_FIX) && !rem_big;
   assign rem  = rem_ff[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Linear probing key set: sequencer, slot memory and result register.
//
// Open-addressing set of nonzero 32-bit keys held in a TABLE_SLOTS-entry slot
// memory, zero marking an empty slot. A request carries a command (search or
// insert) and a key; each request gives exactly one response with found and
// status. After reset the block runs a clearing pass, one slot per cycle, and
// holds req_ready low until it ends. One request at a time is worked on: a
// zero key goes straight to the done state, skipping the remainder unit and
// the slot memory; any other key first goes to the remainder unit, which
// finds the home slot by reciprocal multiplication on one shared multiplier
// (with a correction step when its estimate needs one), then the first slot
// is read, and then P slots, from 1 up to TABLE_SLOTS, are probed, one per
// cycle through the registered read port of the slot memory. The result is
// loaded into the response register once that register is free; req_ready
// returns as it is loaded, so a request occupies the block until its response
// is loaded. A finished response waits in its own register, so the next
// request can be accepted while it is pending.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lph_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lph_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [lph_pkg::KEY_W-1:0] key_ff, key_in;
   logic                      cmd_ff, cmd_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic [IDX_W-1:0]          probes_ff, probes_in;
   logic [IDX_W-1:0]          clr_ff, clr_in;
   lph_pkg::rsp_type          res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lph_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic [lph_pkg::KEY_W-1:0] rdata_ff;

   logic [lph_pkg::KEY_W-1:0] slot_mem [TABLE_SLOTS];
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [lph_pkg::KEY_W-1:0] mem_wdata;
   logic [IDX_W-1:0]          mem_raddr;

   logic                      req_accept;
   logic                      mod_start;
   logic                      mod_done;
   logic [IDX_W-1:0]          mod_rem;
   logic [IDX_W-1:0]          next_pos;
   logic                      slot_empty;
   logic                      slot_hit;

   // Home slot from the remainder unit
   lph_mod_unit #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .op_key (req_data.key),
      .done   (mod_done),
      .rem    (mod_rem)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign mod_start  = req_accept && (req_data.key != '0);

   // Probe position and slot compare
   assign next_pos   = (pos_ff == LAST_IDX) ? '0 : (pos_ff + 1'b1);
   assign slot_empty = (rdata_ff == '0);
   assign slot_hit   = (rdata_ff == key_ff);
   assign mem_raddr  = (state_ff == S_LOAD) ? pos_ff : next_pos;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      probes_in    = probes_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = key_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               key_in = req_data.key;
               cmd_in = req_data.cmd;
               if (req_data.key == '0) begin
                  res_in.found  = 1'b0;
                  res_in.status = lph_pkg::ST_ZERO_KEY;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               pos_in   = mod_rem;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            probes_in = '0;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            if (slot_empty) begin
               res_in.found = 1'b0;
               if (cmd_ff == lph_pkg::CMD_INSERT) begin
                  mem_we        = 1'b1;
                  res_in.status = lph_pkg::ST_INSERTED;
               end else begin
                  res_in.status = lph_pkg::ST_SEARCH;
               end
               state_in = S_DONE;
            end else if (slot_hit) begin
               res_in.found  = 1'b1;
               res_in.status = (cmd_ff == lph_pkg::CMD_INSERT) ?
                               lph_pkg::ST_DUPLICATE : lph_pkg::ST_SEARCH;
               state_in      = S_DONE;
            end else if (probes_ff == LAST_IDX) begin
               // every slot visited with no empty one: table full
               res_in.found  = 1'b0;
               res_in.status = (cmd_ff == lph_pkg::CMD_INSERT) ?
                               lph_pkg::ST_FULL : lph_pkg::ST_SEARCH;
               state_in      = S_DONE;
            end else begin
               pos_in    = next_pos;
               probes_in = probes_ff + 1'b1;
            end
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      probes_ff   <= probes_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= slot_mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LPH_ASSERT_NEXT(a_zero_key, clock, reset,
      req_accept && (req_data.key == '0),
      (state_ff == S_DONE) && (res_ff.status == lph_pkg::ST_ZERO_KEY))
   `LPH_ASSERT_IMPLY(a_mod_done_in_mod, clock, reset, mod_done, state_ff == S_MOD)
   `LPH_ASSERT_IMPLY(a_write_empty_only, clock, reset,
      mem_we && (state_ff != S_CLEAR),
      (state_ff == S_PROBE) && slot_empty && (cmd_ff == lph_pkg::CMD_INSERT))
   `LPH_ASSERT_IMPLY(a_insert_not_found, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == lph_pkg::ST_INSERTED),
      !rsp_data_ff.found)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the linear probing hash table key set.
module testbench;

   localparam int unsigned SLOTS           = 128;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned ITEMS_PER_PHASE = 310;

   // Key set predictor and queue of awaited answers
   class key_set_scoreboard;
      logic [lph_pkg::KEY_W-1:0] slots [SLOTS];
      int unsigned               key_count;
      lph_pkg::rsp_type          awaited_answers [$];
      int unsigned               failures;
      int unsigned               status_seen [5];
      int unsigned               search_hits;

      function new();
         foreach (slots[i]) slots[i] = '0;
         key_count   = 0;
         failures    = 0;
         search_hits = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Probe from the home slot; stop at an empty slot, a match or a full lap
      function bit holds_key(logic [lph_pkg::KEY_W-1:0] key);
         int unsigned pos;
         pos = key % SLOTS;
         for (int unsigned n = 0; n < SLOTS; n++) begin
            if (slots[pos] == '0) return 1'b0;
            if (slots[pos] == key) return 1'b1;
            pos = (pos + 1) % SLOTS;
         end
         return 1'b0;
      endfunction

      // Work out the answer to one request and update the key set
      function lph_pkg::rsp_type predict_answer(lph_pkg::req_type r);
         lph_pkg::rsp_type answer;
         int unsigned      pos;
         answer.found  = 1'b0;
         answer.status = lph_pkg::ST_SEARCH;
         if (r.key == '0) begin
            answer.status = lph_pkg::ST_ZERO_KEY;
         end else if (r.cmd == lph_pkg::CMD_SEARCH) begin
            answer.found = holds_key(r.key);
         end else if (holds_key(r.key)) begin
            answer.found  = 1'b1;
            answer.status = lph_pkg::ST_DUPLICATE;
         end else if (key_count >= SLOTS) begin
            answer.status = lph_pkg::ST_FULL;
         end else begin
            answer.status = lph_pkg::ST_FULL;
            pos = r.key % SLOTS;
            for (int unsigned n = 0; n < SLOTS; n++) begin
               if (slots[pos] == '0) begin
                  slots[pos] = r.key;
                  key_count++;
                  answer.status = lph_pkg::ST_INSERTED;
                  break;
               end
               pos = (pos + 1) % SLOTS;
            end
         end
         return answer;
      endfunction

      function void note_request(lph_pkg::req_type r);
         awaited_answers.push_back(predict_answer(r));
      endfunction

      // Compare a response with the oldest awaited answer
      function void check_response(lph_pkg::rsp_type got);
         lph_pkg::rsp_type want;
         if (awaited_answers.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
            return;
         end
         want = awaited_answers.pop_front();
         if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, got.found);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         status_seen[want.status]++;
         if (want.status == lph_pkg::ST_SEARCH && want.found) search_hits++;
      endfunction

      // Return some key already held, walking forward from a random slot; with none held, a random nonzero key
      function logic [lph_pkg::KEY_W-1:0] pick_stored_key();
         int unsigned pos;
         if (key_count == 0) return $urandom | 32'd1;
         pos = $urandom_range(SLOTS - 1);
         while (slots[pos] == '0) pos = (pos + 1) % SLOTS;
         return slots[pos];
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lph_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lph_pkg::rsp_type  rsp_data;
   int unsigned       sender_idle_pct   = 0;
   int unsigned       receiver_idle_pct = 0;
   int unsigned       cycle_count       = 0;
   key_set_scoreboard board;

   linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial forever #5 clock = ~clock;

   // Check accepted responses and stall the response side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Abandon the run once the cycle limit is reached
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic lph_pkg::req_type make_request(logic cmd,
                                                     logic [lph_pkg::KEY_W-1:0] key);
      lph_pkg::req_type r;
      r.cmd = cmd;
      r.key = key;
      return r;
   endfunction

   // Present one request, idling at random first, and hold it until accepted
   task automatic send_request(input lph_pkg::req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
   endtask

   // Zero keys, empty table, duplicates, collisions and wrap past the last slot
   task automatic run_directed();
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h0000_0000));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'h0000_0000));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h0000_0005));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'h0000_0005));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'h0000_0005));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h0000_0005));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'h0000_0085));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h0000_0085));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'hFFFF_FFFF));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'h0000_007F));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h0000_007F));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h0000_0FFF));
      send_request(make_request(lph_pkg::CMD_INSERT, 32'h8000_0000));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'h8000_0005));
      send_request(make_request(lph_pkg::CMD_SEARCH, 32'hFFFF_FFFF));
   endtask

   // Mix of held keys, keys crowding round the table end, zero and wide keys
   function automatic logic [lph_pkg::KEY_W-1:0] random_key();
      logic [lph_pkg::KEY_W-1:0] k;
      int unsigned               pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         k = '0;
      end else if (pick < 40) begin
         k = board.pick_stored_key();
      end else if (pick < 70) begin
         k = $urandom & ~32'(SLOTS - 1);
         k = k | ((SLOTS - 4 + $urandom_range(7)) % SLOTS);
         if (k == '0) k = SLOTS;
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   task automatic random_requests(input int unsigned count);
      logic cmd;
      for (int unsigned i = 0; i < count; i++) begin
         cmd = ($urandom_range(99) < 35) ? lph_pkg::CMD_INSERT : lph_pkg::CMD_SEARCH;
         send_request(make_request(cmd, random_key()));
      end
   endtask

   initial begin
      board = new;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();

      // Sender idles lightly, receiver heavily; then swap; then no idling
      sender_idle_pct   = 16;
      receiver_idle_pct = 48;
      random_requests(ITEMS_PER_PHASE);
      sender_idle_pct   = 48;
      receiver_idle_pct = 16;
      random_requests(ITEMS_PER_PHASE);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      random_requests(ITEMS_PER_PHASE);
      req_valid <= 1'b0;

      // Drain, then allow time for any stray response
      while (board.awaited_answers.size() != 0) @(posedge clock);
      repeat (2 * SLOTS) @(posedge clock);

      $display("Searches answered: %0d (%0d hits); zero keys rejected: %0d",
               board.status_seen[lph_pkg::ST_SEARCH], board.search_hits,
               board.status_seen[lph_pkg::ST_ZERO_KEY]);
      $display("Inserts stored: %0d, duplicates: %0d, refused as full: %0d; keys held: %0d",
               board.status_seen[lph_pkg::ST_INSERTED],
               board.status_seen[lph_pkg::ST_DUPLICATE],
               board.status_seen[lph_pkg::ST_FULL], board.key_count);
      if (board.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lph_pkg.sv
rtl/lph_mod_unit.sv
rtl/linear_probe_hash_table.sv
bench/testbench.sv
